// ===== hw/rtl/mlsg_pkg.sv =====
package mlsg_pkg;

    localparam int MAX_ORDER = 15;
    localparam int MIN_ORDER = 3;
    localparam int MAX_BLOCK = 64;
    localparam int ORDER_W   = 4;
    localparam int AMP_W     = 23;
    localparam int SAMPLE_W  = 24;
    localparam int COUNT_W   = 7;
    localparam int TAP_W     = 15;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 23;

    localparam logic [CFG_IDX_W-1:0] REG_USE_SEQUENCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SEQ_ORDER    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE    = 2'd2;

    localparam logic [ORDER_W-1:0] RESET_ORDER     = 4'd15;
    localparam logic [AMP_W-1:0]   RESET_AMPLITUDE = 23'h7FFFFF;

    typedef struct packed {
        logic               use_sequence;
        logic [ORDER_W-1:0] seq_order;
        logic [AMP_W-1:0]   amplitude;
    } cfg_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       active;
    } sample_t;

    // Primitive feedback taps for each LFSR order; orders below three are unused.
    function automatic logic [TAP_W-1:0] tap_mask(input logic [ORDER_W-1:0] order);
        logic [TAP_W-1:0] taps;
        begin
            unique case (order)
                4'd3:    taps = 15'h0005;
                4'd4:    taps = 15'h0009;
                4'd5:    taps = 15'h0012;
                4'd6:    taps = 15'h0021;
                4'd7:    taps = 15'h0041;
                4'd8:    taps = 15'h008E;
                4'd9:    taps = 15'h0108;
                4'd10:   taps = 15'h0204;
                4'd11:   taps = 15'h0402;
                4'd12:   taps = 15'h0829;
                4'd13:   taps = 15'h100D;
                4'd14:   taps = 15'h2015;
                4'd15:   taps = 15'h6000;
                default: taps = '0;
            endcase
            return taps;
        end
    endfunction

endpackage

// ===== hw/rtl/mls_impulse_test_signal_generator.sv =====
// Channel  | Handshake                       | Payload
// ---------+---------------------------------+----------------------------------
// request  | req_valid / req_stall           | restart, sample_count
// samples  | smp_valid / smp_stall           | sample, active, last
// config   | cfg_valid / cfg_ready (always 1)| cfg_index, cfg_data
//
// A request of count c (capped at MaxBlock) produces c samples, one per clock while
// the sample side takes them; a count of zero produces no samples.
// The next request is taken in the cycle that produces the last sample.
// Reset loads the register defaults and an all-ones LFSR at order 15.
// A stall on a valid sample holds the output register and stops the LFSR.
module mls_impulse_test_signal_generator #(
    parameter int MaxOrder = mlsg_pkg::MAX_ORDER,
    parameter int MaxBlock = mlsg_pkg::MAX_BLOCK
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    req_valid,
    output logic                                    req_stall,
    input  logic                                    restart,
    input  logic [mlsg_pkg::COUNT_W-1:0]            sample_count,
    output logic                                    smp_valid,
    input  logic                                    smp_stall,
    output logic signed [mlsg_pkg::SAMPLE_W-1:0]    sample,
    output logic                                    active,
    output logic                                    last,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [mlsg_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [mlsg_pkg::CFG_DAT_W-1:0]          cfg_data
);

    localparam int CntW = $clog2(MaxBlock + 1);
    localparam int CmpW = (CntW > mlsg_pkg::COUNT_W) ? CntW : mlsg_pkg::COUNT_W;

    mlsg_pkg::cfg_t      cfg_reg;
    logic [MaxOrder-1:0] lfsr_reg;
    logic [MaxOrder-1:0] lfsr_next;
    logic [MaxOrder-1:0] sample_index_reg;
    logic [MaxOrder-1:0] sample_index_next;
    logic                impulse_done_reg;
    logic                impulse_done_next;
    logic [CntW-1:0]     remain_reg;
    logic [CntW-1:0]     remain_next;
    logic                smp_valid_reg;
    logic                smp_valid_next;
    logic signed [mlsg_pkg::SAMPLE_W-1:0] sample_reg;
    logic                active_reg;
    logic                last_reg;

    logic [MaxOrder-1:0] order_mask;
    logic [MaxOrder-1:0] lfsr_step;
    logic [MaxOrder-1:0] sample_index_step;
    logic                impulse_done_step;
    mlsg_pkg::sample_t   step_result;

    logic                busy;
    logic                gen;
    logic                final_gen;
    logic                req_take;
    logic [CmpW-1:0]     count_ext;
    logic [CntW-1:0]     count_sat;

    mlsg_step #(
        .MaxOrder (MaxOrder)
    ) u_step (
        .cfg               (cfg_reg),
        .lfsr              (lfsr_reg),
        .sample_index      (sample_index_reg),
        .impulse_done      (impulse_done_reg),
        .order_mask        (order_mask),
        .lfsr_step         (lfsr_step),
        .sample_index_step (sample_index_step),
        .impulse_done_step (impulse_done_step),
        .result            (step_result)
    );

    assign busy      = (remain_reg != '0);
    assign gen       = busy && (!smp_valid_reg || !smp_stall);
    assign final_gen = gen && (remain_reg == CntW'(1));
    assign req_stall = busy && !final_gen;
    assign req_take  = req_valid && !req_stall;
    assign cfg_ready = 1'b1;

    assign count_ext = CmpW'(sample_count);
    assign count_sat = (count_ext > CmpW'(MaxBlock)) ? CntW'(MaxBlock) : CntW'(count_ext);

    always_comb
    begin
        lfsr_next         = lfsr_reg;
        sample_index_next = sample_index_reg;
        impulse_done_next = impulse_done_reg;
        if (gen)
        begin
            lfsr_next         = lfsr_step;
            sample_index_next = sample_index_step;
            impulse_done_next = impulse_done_step;
        end
        // A restart applies after the previous request's final sample.
        if (req_take && restart)
        begin
            lfsr_next         = order_mask;
            sample_index_next = '0;
            impulse_done_next = 1'b0;
        end
    end

    always_comb
    begin
        remain_next = remain_reg;
        if (req_take)
        begin
            remain_next = count_sat;
        end
        else if (gen)
        begin
            remain_next = remain_reg - 1'b1;
        end
    end

    always_comb
    begin
        smp_valid_next = smp_valid_reg;
        if (gen)
        begin
            smp_valid_next = 1'b1;
        end
        else if (!smp_stall)
        begin
            smp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.use_sequence <= 1'b0;
            cfg_reg.seq_order    <= mlsg_pkg::RESET_ORDER;
            cfg_reg.amplitude    <= mlsg_pkg::RESET_AMPLITUDE;
            lfsr_reg             <= '1;
            sample_index_reg     <= '0;
            impulse_done_reg     <= 1'b0;
            remain_reg           <= '0;
            smp_valid_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    mlsg_pkg::REG_USE_SEQUENCE: cfg_reg.use_sequence <= cfg_data[0];
                    mlsg_pkg::REG_SEQ_ORDER:
                        cfg_reg.seq_order <= cfg_data[mlsg_pkg::ORDER_W-1:0];
                    mlsg_pkg::REG_AMPLITUDE:
                        cfg_reg.amplitude <= cfg_data[mlsg_pkg::AMP_W-1:0];
                    default: ;
                endcase
            end
            lfsr_reg         <= lfsr_next;
            sample_index_reg <= sample_index_next;
            impulse_done_reg <= impulse_done_next;
            remain_reg       <= remain_next;
            smp_valid_reg    <= smp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (gen)
        begin
            sample_reg <= step_result.sample;
            active_reg <= step_result.active;
            last_reg   <= final_gen;
        end
    end

    assign smp_valid = smp_valid_reg;
    assign sample    = sample_reg;
    assign active    = active_reg;
    assign last      = last_reg;

endmodule

// ===== hw/rtl/mlsg_step.sv =====
module mlsg_step #(
    parameter int MaxOrder = mlsg_pkg::MAX_ORDER
) (
    input  mlsg_pkg::cfg_t       cfg,
    input  logic [MaxOrder-1:0]  lfsr,
    input  logic [MaxOrder-1:0]  sample_index,
    input  logic                 impulse_done,
    output logic [MaxOrder-1:0]  order_mask,
    output logic [MaxOrder-1:0]  lfsr_step,
    output logic [MaxOrder-1:0]  sample_index_step,
    output logic                 impulse_done_step,
    output mlsg_pkg::sample_t    result
);

    logic [mlsg_pkg::ORDER_W-1:0]  order_eff;
    logic [mlsg_pkg::TAP_W-1:0]    taps_full;
    logic [MaxOrder-1:0]           taps;
    logic [MaxOrder-1:0]           state;
    logic                          feedback;
    logic signed [mlsg_pkg::SAMPLE_W-1:0] pos_amp;
    logic signed [mlsg_pkg::SAMPLE_W-1:0] neg_amp;

    always_comb
    begin
        order_eff = cfg.seq_order;
        if (cfg.seq_order < mlsg_pkg::ORDER_W'(mlsg_pkg::MIN_ORDER))
        begin
            order_eff = mlsg_pkg::ORDER_W'(mlsg_pkg::MIN_ORDER);
        end
        else if (cfg.seq_order > mlsg_pkg::ORDER_W'(MaxOrder))
        begin
            order_eff = mlsg_pkg::ORDER_W'(MaxOrder);
        end
    end

    always_comb
    begin
        for (int i = 0; i < MaxOrder; i++)
        begin
            order_mask[i] = (i < int'(order_eff));
        end
    end

    assign taps_full = mlsg_pkg::tap_mask(order_eff);
    assign taps      = taps_full[MaxOrder-1:0];
    assign state     = lfsr & order_mask;
    assign feedback  = ^(state & taps);
    assign pos_amp   = {1'b0, cfg.amplitude};
    assign neg_amp   = -pos_amp;

    always_comb
    begin
        lfsr_step         = lfsr;
        sample_index_step = sample_index;
        impulse_done_step = impulse_done;
        result.sample     = '0;
        result.active     = 1'b0;
        if (cfg.use_sequence)
        begin
            // The sequence length equals the order mask, 2^n - 1.
            if (sample_index < order_mask)
            begin
                result.sample     = state[0] ? pos_amp : neg_amp;
                result.active     = 1'b1;
                lfsr_step         = {state[MaxOrder-2:0], feedback} & order_mask;
                sample_index_step = sample_index + 1'b1;
            end
        end
        else if (!impulse_done)
        begin
            result.sample     = pos_amp;
            result.active     = 1'b1;
            impulse_done_step = 1'b1;
        end
    end

endmodule

// ===== hw/rtl/mlsg_checker.sv =====
module mlsg_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 smp_valid,
    input logic                                 smp_stall,
    input logic signed [mlsg_pkg::SAMPLE_W-1:0] sample,
    input logic                                 active,
    input logic                                 last
);

    // A stalled sample transfer keeps its payload until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        smp_valid && smp_stall |=> smp_valid && $stable(sample) && $stable(active)
            && $stable(last))
    else $error("sample payload changed while stalled");

    // Padding samples carry zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        smp_valid && !active |-> sample == '0)
    else $error("padding sample is not zero");

    // The magnitude is at most full scale, so the most negative code never appears.
    assert property (@(posedge clk) disable iff (!rst_n)
        smp_valid |-> sample != {1'b1, {(mlsg_pkg::SAMPLE_W-1){1'b0}}})
    else $error("sample outside Q1.23 range");

endmodule

bind mls_impulse_test_signal_generator mlsg_checker u_mlsg_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .smp_valid (smp_valid),
    .smp_stall (smp_stall),
    .sample    (sample),
    .active    (active),
    .last      (last)
);
